@@ design/tdsd_pkg.sv @@
// Shared constants and types for the third-difference spike detector.
package tdsd_pkg;

   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF    = 16;

   localparam int ALPHA_W    = 17;
   localparam int THR_W      = 34;
   localparam int REARM_W    = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 34;
   localparam int COUNT_W    = 32;
   localparam int FILL_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REARM     = 2'd2;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
   localparam logic [THR_W-1:0]   THR_RESET   = 34'd65536;
   localparam logic [REARM_W-1:0] REARM_RESET = 17'd13107;

   localparam logic [FILL_W-1:0] FILL_NONE = 2'd0;
   localparam logic [FILL_W-1:0] FILL_VEL  = 2'd1;
   localparam logic [FILL_W-1:0] FILL_ACC  = 2'd2;
   localparam logic [FILL_W-1:0] FILL_JERK = 2'd3;

   typedef struct packed {
      logic             restart;
      logic [THR_W-1:0] threshold;
      logic [THR_W-1:0] rearm_level;
   } csr_ctrl_type;

endpackage

@@ design/tdsd_csr.sv @@
// Configuration registers, alpha clamp and registered re-arm level.
module tdsd_csr #(
   parameter int FRAC_BITS = tdsd_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tdsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsd_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [FRAC_BITS:0]               alpha,
   output tdsd_pkg::csr_ctrl_type           ctrl
);
   import tdsd_pkg::*;

   localparam int AW = FRAC_BITS + 1;
   localparam int CW = (ALPHA_W > AW) ? ALPHA_W : AW;
   localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
   localparam logic [AW-1:0] ONE_A = AW'(1) << FRAC_BITS;
   localparam int PW = THR_W + AW;

   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [THR_W-1:0]   thr_ff, thr_in;
   logic [REARM_W-1:0] rearm_ff, rearm_in;
   logic [THR_W-1:0]   level_ff, level_in;
   logic               write;
   logic [AW-1:0]      one_minus;
   logic [PW-1:0]      level_prod;

   // values above 1.0 saturate
   function automatic logic [AW-1:0] clamp_one(input logic [ALPHA_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w > ONE_C) begin
         w = ONE_C;
      end
      return AW'(w);
   endfunction

   assign csr_ready = 1'b1;
   assign write     = csr_valid && csr_ready;

   always_comb begin
      alpha_in = alpha_ff;
      thr_in   = thr_ff;
      rearm_in = rearm_ff;
      if (write) begin
         case (csr_index)
            CSR_ALPHA:     alpha_in = csr_data[ALPHA_W-1:0];
            CSR_THRESHOLD: thr_in   = csr_data[THR_W-1:0];
            CSR_REARM:     rearm_in = csr_data[REARM_W-1:0];
            default:       ;
         endcase
      end
   end

   assign one_minus  = ONE_A - clamp_one(rearm_ff);
   assign level_prod = PW'(thr_ff) * PW'(one_minus);
   assign level_in   = level_prod[THR_W+FRAC_BITS-1:FRAC_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         thr_ff   <= THR_RESET;
         rearm_ff <= REARM_RESET;
      end else begin
         alpha_ff <= alpha_in;
         thr_ff   <= thr_in;
         rearm_ff <= rearm_in;
      end
   end

   // level is registered from the registers above; loads during reset too
   always_ff @(posedge clock) begin
      level_ff <= level_in;
   end

   assign alpha            = clamp_one(alpha_ff);
   assign ctrl.restart     = write && (csr_index == CSR_ALPHA || csr_index == CSR_THRESHOLD
                                       || csr_index == CSR_REARM);
   assign ctrl.threshold   = thr_ff;
   assign ctrl.rearm_level = level_ff;

endmodule

@@ design/tdsd_ema.sv @@
// One exponential moving average step: ema + floor(alpha * (d - ema) / 2^F).
module tdsd_ema #(
   parameter int DW        = 33,
   parameter int FRAC_BITS = tdsd_pkg::FRAC_BITS_DEF
) (
   input  logic signed [DW-1:0]  ema,
   input  logic signed [DW-1:0]  d,
   input  logic [FRAC_BITS:0]    alpha,
   output logic signed [DW-1:0]  ema_next
);
   import tdsd_pkg::*;

   localparam int PW = DW + FRAC_BITS + 3;

   logic signed [DW:0]   diff;
   logic signed [PW-1:0] diff_x;
   logic signed [PW-1:0] alpha_x;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] step;

   assign diff     = (DW+1)'(d) - (DW+1)'(ema);
   assign diff_x   = PW'(diff);
   assign alpha_x  = PW'({1'b0, alpha});
   assign prod     = diff_x * alpha_x;
   // arithmetic shift gives the floor
   assign step     = prod >>> FRAC_BITS;
   // the true result stays within the range of d, so modular add is exact
   assign ema_next = ema + DW'(step);

endmodule

@@ design/third_difference_spike_detector_core.sv @@
// Third-difference spike detector: top level with input register, state and result register.
// Update: three differences, three EMA multiplies, spike and re-arm compares, all sitting
//   between the input register, where an accepted sample waits, and the result register.
// Throughput: one sample per cycle while no stalled result beat holds the input register.
// Reset: synchronous, active high; clears history, EMAs, shown values and counts, arms
//   the detector and loads the register defaults. A mapped write restarts the history.
module third_difference_spike_detector_core #(
   parameter int SAMPLE_WIDTH = tdsd_pkg::SAMPLE_WIDTH_DEF,
   parameter int FRAC_BITS    = tdsd_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // sample beats
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   // result beats
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [SAMPLE_WIDTH:0]     rsp_velocity,
   output logic signed [SAMPLE_WIDTH:0]     rsp_velocity_avg,
   output logic signed [SAMPLE_WIDTH+1:0]   rsp_acceleration,
   output logic signed [SAMPLE_WIDTH+1:0]   rsp_acceleration_avg,
   output logic signed [SAMPLE_WIDTH+2:0]   rsp_jerk,
   output logic signed [SAMPLE_WIDTH+2:0]   rsp_jerk_avg,
   output logic                             rsp_spike,
   output logic [tdsd_pkg::FILL_W-1:0]      rsp_fill_level,
   output logic [tdsd_pkg::COUNT_W-1:0]     rsp_sample_count,
   output logic [tdsd_pkg::COUNT_W-1:0]     rsp_spike_count,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tdsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tdsd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import tdsd_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int VW = SW + 1;   // first difference
   localparam int AW = SW + 2;   // second difference
   localparam int JW = SW + 3;   // third difference
   localparam int MW = (JW > THR_W) ? JW : THR_W;

   // ---------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------
   logic [FRAC_BITS:0] alpha;
   csr_ctrl_type       ctrl;

   tdsd_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .alpha     (alpha),
      .ctrl      (ctrl)
   );

   // ---------------------------------------------------------------
   // Handshake: input register feeds the result register; the input
   // side only stalls while a full input register faces a stalled result.
   // ---------------------------------------------------------------
   logic                 s1_valid_ff, s1_valid_in;
   logic signed [SW-1:0] s1_sample_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_accept;
   logic                 advance;

   assign advance      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = s1_valid_ff && !advance;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_sample_ff <= req_sample;
      end
   end

   // ---------------------------------------------------------------
   // History and filter state
   // ---------------------------------------------------------------
   logic signed [SW-1:0] last_sample_ff, last_sample_in;
   logic signed [VW-1:0] last_vel_ff, last_vel_in;
   logic signed [AW-1:0] last_acc_ff, last_acc_in;
   logic signed [VW-1:0] vema_ff, vema_in;
   logic signed [AW-1:0] aema_ff, aema_in;
   logic signed [JW-1:0] jema_ff, jema_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic                 armed_ff, armed_in;
   logic [COUNT_W-1:0]   obs_ff, obs_in;
   logic [COUNT_W-1:0]   spikes_ff, spikes_in;

   // result register (shown values double as model state)
   logic signed [VW-1:0] shown_vel_ff, shown_vel_in;
   logic signed [VW-1:0] shown_vema_ff, shown_vema_in;
   logic signed [AW-1:0] shown_acc_ff, shown_acc_in;
   logic signed [AW-1:0] shown_aema_ff, shown_aema_in;
   logic signed [JW-1:0] shown_jerk_ff, shown_jerk_in;
   logic signed [JW-1:0] shown_jema_ff, shown_jema_in;
   logic                 spike_ff, spike_in;
   logic [FILL_W-1:0]    rsp_fill_ff, rsp_fill_in;

   // ---------------------------------------------------------------
   // Datapath: differences, EMA steps, magnitude compares
   // ---------------------------------------------------------------
   logic signed [VW-1:0] d1;
   logic signed [AW-1:0] d2;
   logic signed [JW-1:0] d3;
   logic signed [VW-1:0] vema_next;
   logic signed [AW-1:0] aema_next;
   logic signed [JW-1:0] jema_next;
   logic [JW-1:0]        mag_d3;
   logic [JW-1:0]        mag_jema;
   logic                 fire;
   logic                 rearm;

   assign d1 = VW'(s1_sample_ff) - VW'(last_sample_ff);
   assign d2 = AW'(d1) - AW'(last_vel_ff);
   assign d3 = JW'(d2) - JW'(last_acc_ff);

   tdsd_ema #(.DW (VW), .FRAC_BITS (FRAC_BITS)) u_vel_ema (
      .ema (vema_ff), .d (d1), .alpha (alpha), .ema_next (vema_next)
   );

   tdsd_ema #(.DW (AW), .FRAC_BITS (FRAC_BITS)) u_acc_ema (
      .ema (aema_ff), .d (d2), .alpha (alpha), .ema_next (aema_next)
   );

   tdsd_ema #(.DW (JW), .FRAC_BITS (FRAC_BITS)) u_jerk_ema (
      .ema (jema_ff), .d (d3), .alpha (alpha), .ema_next (jema_next)
   );

   // two's complement negate; the most negative value maps to its unsigned magnitude
   assign mag_d3   = d3[JW-1] ? JW'(-d3) : JW'(d3);
   assign mag_jema = jema_next[JW-1] ? JW'(-jema_next) : JW'(jema_next);

   // spike and re-arm only matter once jerk is valid
   assign fire  = armed_ff && (MW'(mag_d3) > MW'(ctrl.threshold));
   assign rearm = !armed_ff && (MW'(mag_jema) < MW'(ctrl.rearm_level));

   always_comb begin
      last_sample_in = last_sample_ff;
      last_vel_in    = last_vel_ff;
      last_acc_in    = last_acc_ff;
      vema_in        = vema_ff;
      aema_in        = aema_ff;
      jema_in        = jema_ff;
      fill_in        = fill_ff;
      armed_in       = armed_ff;
      obs_in         = obs_ff;
      spikes_in      = spikes_ff;
      shown_vel_in   = shown_vel_ff;
      shown_vema_in  = shown_vema_ff;
      shown_acc_in   = shown_acc_ff;
      shown_aema_in  = shown_aema_ff;
      shown_jerk_in  = shown_jerk_ff;
      shown_jema_in  = shown_jema_ff;
      spike_in       = spike_ff;
      rsp_fill_in    = rsp_fill_ff;

      if (advance) begin
         obs_in         = obs_ff + COUNT_W'(1);
         last_sample_in = s1_sample_ff;
         spike_in       = 1'b0;

         // velocity once one sample of history exists
         if (fill_ff != FILL_NONE) begin
            vema_in       = vema_next;
            shown_vel_in  = d1;
            shown_vema_in = vema_next;
            last_vel_in   = d1;
         end

         // acceleration once two
         if (fill_ff inside {FILL_ACC, FILL_JERK}) begin
            aema_in       = aema_next;
            shown_acc_in  = d2;
            shown_aema_in = aema_next;
            last_acc_in   = d2;
         end

         case (fill_ff)
            FILL_NONE: fill_in = FILL_VEL;
            FILL_VEL:  fill_in = FILL_ACC;
            FILL_ACC:  fill_in = FILL_JERK;
            default: begin
               jema_in       = jema_next;
               shown_jerk_in = d3;
               shown_jema_in = jema_next;
               if (fire) begin
                  armed_in  = 1'b0;
                  spike_in  = 1'b1;
                  spikes_in = spikes_ff + COUNT_W'(1);
               end else if (rearm) begin
                  armed_in = 1'b1;
               end
            end
         endcase

         rsp_fill_in = fill_in;
      end

      // config write to a mapped index: history restarts, shown values and counts stay
      if (ctrl.restart) begin
         last_sample_in = '0;
         last_vel_in    = '0;
         last_acc_in    = '0;
         vema_in        = '0;
         aema_in        = '0;
         jema_in        = '0;
         fill_in        = FILL_NONE;
         armed_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         last_vel_ff    <= '0;
         last_acc_ff    <= '0;
         vema_ff        <= '0;
         aema_ff        <= '0;
         jema_ff        <= '0;
         fill_ff        <= FILL_NONE;
         armed_ff       <= 1'b1;
         obs_ff         <= '0;
         spikes_ff      <= '0;
         shown_vel_ff   <= '0;
         shown_vema_ff  <= '0;
         shown_acc_ff   <= '0;
         shown_aema_ff  <= '0;
         shown_jerk_ff  <= '0;
         shown_jema_ff  <= '0;
         spike_ff       <= 1'b0;
         rsp_fill_ff    <= FILL_NONE;
      end else begin
         last_sample_ff <= last_sample_in;
         last_vel_ff    <= last_vel_in;
         last_acc_ff    <= last_acc_in;
         vema_ff        <= vema_in;
         aema_ff        <= aema_in;
         jema_ff        <= jema_in;
         fill_ff        <= fill_in;
         armed_ff       <= armed_in;
         obs_ff         <= obs_in;
         spikes_ff      <= spikes_in;
         shown_vel_ff   <= shown_vel_in;
         shown_vema_ff  <= shown_vema_in;
         shown_acc_ff   <= shown_acc_in;
         shown_aema_ff  <= shown_aema_in;
         shown_jerk_ff  <= shown_jerk_in;
         shown_jema_ff  <= shown_jema_in;
         spike_ff       <= spike_in;
         rsp_fill_ff    <= rsp_fill_in;
      end
   end

   // ---------------------------------------------------------------
   // Result beat
   // ---------------------------------------------------------------
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_velocity         = shown_vel_ff;
   assign rsp_velocity_avg     = shown_vema_ff;
   assign rsp_acceleration     = shown_acc_ff;
   assign rsp_acceleration_avg = shown_aema_ff;
   assign rsp_jerk             = shown_jerk_ff;
   assign rsp_jerk_avg         = shown_jema_ff;
   assign rsp_spike            = spike_ff;
   assign rsp_fill_level       = rsp_fill_ff;
   assign rsp_sample_count     = obs_ff;
   assign rsp_spike_count      = spikes_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_spike_needs_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && spike_ff |-> rsp_fill_ff == FILL_JERK)
      else $error("spike reported before jerk history was full");

   a_spike_counted: assert property (@(posedge clock) disable iff (reset)
      advance && fill_ff == FILL_JERK && fire |=> spikes_ff == $past(spikes_ff) + COUNT_W'(1))
      else $error("fired spike not counted");

   a_disarm_on_spike: assert property (@(posedge clock) disable iff (reset)
      advance && fill_ff == FILL_JERK && fire && !ctrl.restart |=> !armed_ff)
      else $error("detector still armed after a spike");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the third-difference spike detector core.
module testbench;
   import tdsd_pkg::*;

   localparam int SW          = SAMPLE_WIDTH_DEF;
   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
   localparam int PRINT_CAP   = 50;

   localparam logic [ALPHA_W-1:0]   UNITY     = 17'd65536;   // 1.0 in Q1.16
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;        // unmapped index

   // one queued sample beat; hold makes the driver wait for all readouts first
   typedef struct packed {
      logic          hold;
      logic [SW-1:0] value;
   } sample_beat_type;

   typedef struct packed {
      logic [SW:0]          velocity;
      logic [SW:0]          velocity_avg;
      logic [SW+1:0]        acceleration;
      logic [SW+1:0]        acceleration_avg;
      logic [SW+2:0]        jerk;
      logic [SW+2:0]        jerk_avg;
      logic                 spike;
      logic [FILL_W-1:0]    fill_level;
      logic [COUNT_W-1:0]   sample_count;
      logic [COUNT_W-1:0]   spike_count;
   } readout_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [SW-1:0]         req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SW:0]           rsp_velocity;
   logic [SW:0]           rsp_velocity_avg;
   logic [SW+1:0]         rsp_acceleration;
   logic [SW+1:0]         rsp_acceleration_avg;
   logic [SW+2:0]         rsp_jerk;
   logic [SW+2:0]         rsp_jerk_avg;
   logic                  rsp_spike;
   logic [FILL_W-1:0]     rsp_fill_level;
   logic [COUNT_W-1:0]    rsp_sample_count;
   logic [COUNT_W-1:0]    rsp_spike_count;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   third_difference_spike_detector_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_velocity         (rsp_velocity),
      .rsp_velocity_avg     (rsp_velocity_avg),
      .rsp_acceleration     (rsp_acceleration),
      .rsp_acceleration_avg (rsp_acceleration_avg),
      .rsp_jerk             (rsp_jerk),
      .rsp_jerk_avg         (rsp_jerk_avg),
      .rsp_spike            (rsp_spike),
      .rsp_fill_level       (rsp_fill_level),
      .rsp_sample_count     (rsp_sample_count),
      .rsp_spike_count      (rsp_spike_count),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Detector model: register copies, difference history and shown values
   // ---------------------------------------------------------------------
   logic [ALPHA_W-1:0]    alpha_reg;
   logic [THR_W-1:0]      threshold_reg;
   logic [REARM_W-1:0]    rearm_reg;

   logic signed [SW-1:0]  prev_sample;
   logic signed [63:0]    prev_velocity;
   logic signed [63:0]    prev_acceleration;
   logic signed [63:0]    vel_smooth;
   logic signed [63:0]    acc_smooth;
   logic signed [63:0]    jerk_smooth;
   logic [FILL_W-1:0]     fill;
   logic                  armed;
   logic signed [63:0]    shown_velocity, shown_vel_smooth;
   logic signed [63:0]    shown_acceleration, shown_acc_smooth;
   logic signed [63:0]    shown_jerk, shown_jerk_smooth;
   logic [COUNT_W-1:0]    sample_total;
   logic [COUNT_W-1:0]    spike_total;

   sample_beat_type queued_samples[$];
   readout_type     predicted_readouts[$];

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int sender_idle_pct;
   int receiver_stall_pct;
   int path_level = 0;    // smooth trajectory for well-formed stimulus
   int path_slope = 0;
   logic req_took = 1'b0;

   // Q1.16 weights above 1.0 act as 1.0
   function automatic logic [ALPHA_W-1:0] clamp_unity(input logic [ALPHA_W-1:0] w);
      return (w > UNITY) ? UNITY : w;
   endfunction

   // ema + floor(alpha * (d - ema) / 2^FRAC); arithmetic shift gives the floor
   function automatic logic signed [63:0] ema_next(input logic signed [63:0] acc,
                                                   input logic signed [63:0] d);
      logic signed [63:0] w;
      w = {47'd0, clamp_unity(alpha_reg)};
      return acc + (((d - acc) * w) >>> FRAC);
   endfunction

   function automatic logic [63:0] magnitude(input logic signed [63:0] x);
      return (x < 0) ? -x : x;
   endfunction

   // floor(threshold * (1 - rearm) ), rearm clamped to 1.0
   function automatic logic [63:0] rearm_level();
      logic [63:0] keep;
      keep = 64'(UNITY) - 64'(clamp_unity(rearm_reg));
      return ({30'd0, threshold_reg} * keep) >> FRAC;
   endfunction

   // a config write drops the history and re-arms; shown values and counts stay
   function automatic void clear_history();
      prev_sample       = '0;
      prev_velocity     = '0;
      prev_acceleration = '0;
      vel_smooth        = '0;
      acc_smooth        = '0;
      jerk_smooth       = '0;
      fill              = FILL_NONE;
      armed             = 1'b1;
   endfunction

   function automatic void reset_detector_model();
      alpha_reg          = ALPHA_RESET;
      threshold_reg      = THR_RESET;
      rearm_reg          = REARM_RESET;
      clear_history();
      shown_velocity     = '0;
      shown_vel_smooth   = '0;
      shown_acceleration = '0;
      shown_acc_smooth   = '0;
      shown_jerk         = '0;
      shown_jerk_smooth  = '0;
      sample_total       = '0;
      spike_total        = '0;
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_ALPHA: begin
            alpha_reg = val[ALPHA_W-1:0];
            clear_history();
         end
         CSR_THRESHOLD: begin
            threshold_reg = val[THR_W-1:0];
            clear_history();
         end
         CSR_REARM: begin
            rearm_reg = val[REARM_W-1:0];
            clear_history();
         end
         default: ;   // unmapped index: no effect, history kept
      endcase
   endfunction

   // one sample in, one readout out; differences open up as the fill count grows
   function automatic readout_type advance_derivatives(input logic [SW-1:0] raw);
      logic signed [SW-1:0] s;
      logic signed [63:0]   d1, d2, d3;
      logic                 fired;
      readout_type          r;
      s            = raw;
      fired        = 1'b0;
      sample_total = sample_total + COUNT_W'(1);
      if (fill == FILL_NONE) begin
         prev_sample = s;
         fill        = FILL_VEL;
      end else begin
         d1               = 64'(s) - 64'(prev_sample);
         prev_sample      = s;
         vel_smooth       = ema_next(vel_smooth, d1);
         shown_velocity   = d1;
         shown_vel_smooth = vel_smooth;
         if (fill == FILL_VEL) begin
            prev_velocity = d1;
            fill          = FILL_ACC;
         end else begin
            d2                 = d1 - prev_velocity;
            prev_velocity      = d1;
            acc_smooth         = ema_next(acc_smooth, d2);
            shown_acceleration = d2;
            shown_acc_smooth   = acc_smooth;
            if (fill == FILL_ACC) begin
               prev_acceleration = d2;
               fill              = FILL_JERK;
            end else begin
               d3                = d2 - prev_acceleration;
               prev_acceleration = d2;
               jerk_smooth       = ema_next(jerk_smooth, d3);
               shown_jerk        = d3;
               shown_jerk_smooth = jerk_smooth;
               // fire while armed; the re-arm check only runs on a quiet step
               if (armed && magnitude(d3) > {30'd0, threshold_reg}) begin
                  armed       = 1'b0;
                  fired       = 1'b1;
                  spike_total = spike_total + COUNT_W'(1);
               end else if (!armed) begin
                  if (magnitude(jerk_smooth) < rearm_level()) armed = 1'b1;
               end
            end
         end
      end
      r.velocity         = shown_velocity[SW:0];
      r.velocity_avg     = shown_vel_smooth[SW:0];
      r.acceleration     = shown_acceleration[SW+1:0];
      r.acceleration_avg = shown_acc_smooth[SW+1:0];
      r.jerk             = shown_jerk[SW+2:0];
      r.jerk_avg         = shown_jerk_smooth[SW+2:0];
      r.spike            = fired;
      r.fill_level       = fill;
      r.sample_count     = sample_total;
      r.spike_count      = spike_total;
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Sample driver: presents queued beats at the falling edge. A beat stays
   // put until the edge that takes it; then the next one (or a gap) follows.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (queued_samples.size() == 0 || $urandom_range(0, 99) < sender_idle_pct) begin
            req_valid <= 1'b0;
         end else if (queued_samples[0].hold && predicted_readouts.size() != 0) begin
            // hold-off: let every outstanding readout drain first
            req_valid <= 1'b0;
         end else begin
            req_sample <= queued_samples[0].value;
            req_valid  <= 1'b1;
            void'(queued_samples.pop_front());
         end
      end
   end

   // readout backpressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor at the rising edge: check the readout beat against the oldest
   // prediction first, then predict for a sample taken at this same edge.
   // Also runs the watchdog on cycles where no channel moves a beat.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      readout_type want;
      if (reset) begin
         req_took     <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (rsp_valid && !rsp_stall) begin
            if (predicted_readouts.size() == 0) begin
               flag_mismatch("readout with none predicted", rsp_sample_count, '0);
            end else begin
               want = predicted_readouts.pop_front();
               if (rsp_velocity !== want.velocity)
                  flag_mismatch("velocity", rsp_velocity, want.velocity);
               if (rsp_velocity_avg !== want.velocity_avg)
                  flag_mismatch("velocity_avg", rsp_velocity_avg, want.velocity_avg);
               if (rsp_acceleration !== want.acceleration)
                  flag_mismatch("acceleration", rsp_acceleration, want.acceleration);
               if (rsp_acceleration_avg !== want.acceleration_avg)
                  flag_mismatch("acceleration_avg", rsp_acceleration_avg,
                                want.acceleration_avg);
               if (rsp_jerk !== want.jerk)
                  flag_mismatch("jerk", rsp_jerk, want.jerk);
               if (rsp_jerk_avg !== want.jerk_avg)
                  flag_mismatch("jerk_avg", rsp_jerk_avg, want.jerk_avg);
               if (rsp_spike !== want.spike)
                  flag_mismatch("spike", rsp_spike, want.spike);
               if (rsp_fill_level !== want.fill_level)
                  flag_mismatch("fill_level", rsp_fill_level, want.fill_level);
               if (rsp_sample_count !== want.sample_count)
                  flag_mismatch("sample_count", rsp_sample_count, want.sample_count);
               if (rsp_spike_count !== want.spike_count)
                  flag_mismatch("spike_count", rsp_spike_count, want.spike_count);
            end
         end
         if (req_valid && !req_stall)
            predicted_readouts.push_back(advance_derivatives(req_sample));

         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequencing
   // ---------------------------------------------------------------------
   task automatic push_sample(input logic [SW-1:0] v, input logic hold);
      sample_beat_type beat;
      beat.hold  = hold;
      beat.value = v;
      queued_samples.push_back(beat);
   endtask

   // A few full-range beats at the start, then a drifting ramp with small
   // noise and rare steps: steps fire spikes, the calm stretches let the
   // jerk average decay so the detector re-arms.
   task automatic queue_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i < 8 || $urandom_range(0, 99) == 0) begin
            push_sample($urandom, $urandom_range(0, 99) < 2);
         end else begin
            if ($urandom_range(0, 99) < 5)
               path_slope = int'($urandom_range(0, 8190)) - 4095;
            if ($urandom_range(0, 99) < 3)
               path_level = path_level + int'($urandom_range(0, 2097152)) - 1048576;
            path_level = path_level + path_slope;
            push_sample(path_level + int'($urandom_range(0, 2046)) - 1023,
                        $urandom_range(0, 99) < 2);
         end
      end
   endtask

   // block is idle once the sample queue is empty and every readout is back
   task automatic wait_idle();
      while (queued_samples.size() != 0 || req_valid || predicted_readouts.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [ALPHA_W-1:0] alpha, input logic [THR_W-1:0] thr,
                            input logic [REARM_W-1:0] rearm, input int count);
      wait_idle();
      write_reg(CSR_ALPHA, CSR_DATA_W'(alpha));
      write_reg(CSR_THRESHOLD, CSR_DATA_W'(thr));
      write_reg(CSR_REARM, CSR_DATA_W'(rearm));
      queue_random(count);
   endtask

   initial begin
      reset_detector_model();
      sender_idle_pct    = 8;
      receiver_stall_pct = 87;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: quiet fill, a clean spike, then full-scale
      // swings for the widest differences, sign edges and bit patterns
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h0004_0000, 1'b0);
      push_sample(32'h0004_0000, 1'b0);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h8000_0000, 1'b0);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'hFFFF_FFFF, 1'b0);
      push_sample(32'h0000_0000, 1'b0);
      push_sample(32'h0000_0001, 1'b0);
      push_sample(32'h5555_5555, 1'b0);
      push_sample(32'hAAAA_AAAA, 1'b0);
      push_sample(32'h8000_0000, 1'b0);
      push_sample(32'h8000_0000, 1'b0);
      queue_random(150);

      // full-weight average, zero threshold: one spike, never re-armed
      run_phase(UNITY, '0, '0, 140);

      sender_idle_pct    = 87;
      receiver_stall_pct = 8;
      // zero weight, threshold at its top: averages frozen, no spikes
      run_phase('0, '1, UNITY, 140);
      // weight and fraction above 1.0 saturate
      run_phase('1, 34'd196608, '1, 140);

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      run_phase(ALPHA_W'($urandom_range(0, 131071)), THR_W'($urandom_range(4096, 4194304)),
                REARM_W'($urandom_range(0, 131071)), 140);
      run_phase(17'd32768, 34'd1048576, 17'd16384, 120);

      // unmapped index must leave history and fill untouched
      wait_idle();
      write_reg(CSR_SPARE, '1);
      queue_random(60);
      wait_idle();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
design/tdsd_pkg.sv
design/tdsd_csr.sv
design/tdsd_ema.sv
design/third_difference_spike_detector_core.sv
bench/testbench.sv
